// ===== sv/kta_pkg.sv =====
package kta_pkg;

  // Modifier and lock keys
  localparam logic [7:0] KeyLeftCtrl   = 8'h01;
  localparam logic [7:0] KeyLeftShift  = 8'h02;
  localparam logic [7:0] KeyRightShift = 8'h03;
  localparam logic [7:0] KeyLeftAlt    = 8'h39;
  localparam logic [7:0] KeyCapsLock   = 8'h3A;

  // Character key ranges
  localparam logic [7:0] KeyLetterA    = 8'h04;
  localparam logic [7:0] KeyLetterZ    = 8'h1D;
  localparam logic [7:0] KeyDigit1     = 8'h1E;
  localparam logic [7:0] KeyDigit9     = 8'h26;
  localparam logic [7:0] KeyDigit0     = 8'h27;
  localparam logic [7:0] KeyEnter      = 8'h28;
  localparam logic [7:0] KeyBackspace  = 8'h2A;
  localparam logic [7:0] KeyTab        = 8'h2B;
  localparam logic [7:0] KeySpace      = 8'h2C;
  localparam logic [7:0] KeyPunctFirst = 8'h2D;
  localparam logic [7:0] KeyPunctLast  = 8'h38;

  localparam logic [6:0] AsciiCaseBit  = 7'h20;

  // Held modifiers and the caps lock toggle
  typedef struct packed {
    logic caps;
    logic lalt;
    logic lctrl;
    logic rshift;
    logic lshift;
  } mods_t;

  // Shifted digit row, index 0 is the '1' key
  function automatic logic [6:0] digit_shifted(input logic [3:0] idx);
    logic [6:0] c;
    case (idx)
      4'd0:    c = 7'(int'("!"));
      4'd1:    c = 7'(int'("@"));
      4'd2:    c = 7'(int'("#"));
      4'd3:    c = 7'(int'("$"));
      4'd4:    c = 7'(int'("%"));
      4'd5:    c = 7'(int'("^"));
      4'd6:    c = 7'(int'("&"));
      4'd7:    c = 7'(int'("*"));
      4'd8:    c = 7'(int'("("));
      default: c = '0;
    endcase
    return c;
  endfunction

  // Punctuation keys from the minus key on; the non-US hash slot is unmapped
  function automatic logic [6:0] punct_char(input logic [3:0] idx, input logic shift);
    logic [6:0] c;
    case (idx)
      4'd0:    c = shift ? 7'h5F : 7'h2D;
      4'd1:    c = shift ? 7'h2B : 7'h3D;
      4'd2:    c = shift ? 7'h7B : 7'h5B;
      4'd3:    c = shift ? 7'h7D : 7'h5D;
      4'd4:    c = shift ? 7'h7C : 7'h5C;
      4'd6:    c = shift ? 7'h3A : 7'h3B;
      4'd7:    c = shift ? 7'h22 : 7'h27;
      4'd8:    c = shift ? 7'h7E : 7'h60;
      4'd9:    c = shift ? 7'h3C : 7'h2C;
      4'd10:   c = shift ? 7'h3E : 7'h2E;
      4'd11:   c = shift ? 7'h3F : 7'h2F;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Character for a pressed key under the given modifiers, zero if unmapped
  function automatic logic [6:0] decode_char(input logic [7:0] kc, input mods_t mods);
    logic       shift;
    logic [7:0] off;
    logic [6:0] c;
    shift = mods.lshift | mods.rshift;
    c     = '0;
    if (kc >= KeyLetterA && kc <= KeyLetterZ) begin
      off = kc - KeyLetterA;
      c   = 7'h61 + off[6:0];
      if (shift ^ mods.caps) begin
        c = c - AsciiCaseBit;
      end
    end else if (kc >= KeyDigit1 && kc <= KeyDigit9) begin
      off = kc - KeyDigit1;
      c   = shift ? digit_shifted(off[3:0]) : 7'h31 + off[6:0];
    end else if (kc == KeyDigit0) begin
      c = shift ? 7'h29 : 7'h30;
    end else if (kc == KeyEnter) begin
      c = 7'h0A;
    end else if (kc == KeyBackspace) begin
      c = 7'h08;
    end else if (kc == KeyTab) begin
      c = 7'h09;
    end else if (kc == KeySpace) begin
      c = 7'h20;
    end else if (kc >= KeyPunctFirst && kc <= KeyPunctLast) begin
      off = kc - KeyPunctFirst;
      c   = punct_char(off[3:0], shift);
    end
    return c;
  endfunction

endpackage

// ===== sv/keycode_to_ascii_with_modifiers_unit.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | key_code_i, key_press_i
// out     | output    | out_valid_o / out_stall_i | char_valid_o, char_code_o,
//         |           |                           | *_held_o, caps_lock_on_o
//
// One key event per cycle while the input is not stalled; the result appears in the cycle after its event is accepted,
// set by the single result register behind the modifier update and decode.
// Reset clears the modifier state and the result valid; no clearing pass.
// A stalled result holds; the input stalls only while a held result is stalled,
// and takes the next event in the same cycle the held result leaves.
module keycode_to_ascii_with_modifiers_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_code_i,
  input  logic       key_press_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       char_valid_o,
  output logic [6:0] char_code_o,
  output logic       left_shift_held_o,
  output logic       right_shift_held_o,
  output logic       left_ctrl_held_o,
  output logic       left_alt_held_o,
  output logic       caps_lock_on_o
);

  kta_pkg::mods_t mods_q, mods_d;
  kta_pkg::mods_t res_mods_q;
  logic           out_valid_q, out_valid_d;
  logic [6:0]     char_q, char_d;
  logic           in_accept;

  // Stall input only while a held result cannot leave
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Update modifiers, then decode the press under the new state
  always_comb begin
    mods_d = mods_q;
    case (key_code_i)
      kta_pkg::KeyLeftShift:  mods_d.lshift = key_press_i;
      kta_pkg::KeyRightShift: mods_d.rshift = key_press_i;
      kta_pkg::KeyLeftCtrl:   mods_d.lctrl  = key_press_i;
      kta_pkg::KeyLeftAlt:    mods_d.lalt   = key_press_i;
      kta_pkg::KeyCapsLock:   mods_d.caps   = mods_q.caps ^ key_press_i;
      default:                mods_d        = mods_q;
    endcase
    char_d = key_press_i ? kta_pkg::decode_char(key_code_i, mods_d) : '0;
  end

  // Result valid: set on accept, clear when the beat leaves
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        mods_q <= mods_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q     <= char_d;
      res_mods_q <= mods_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign char_valid_o       = char_q != '0;
  assign char_code_o        = char_q;
  assign left_shift_held_o  = res_mods_q.lshift;
  assign right_shift_held_o = res_mods_q.rshift;
  assign left_ctrl_held_o   = res_mods_q.lctrl;
  assign left_alt_held_o    = res_mods_q.lalt;
  assign caps_lock_on_o     = res_mods_q.caps;

  // A release never yields a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !key_press_i) |=> !char_valid_o)
    else $error("character produced on key release");

  // Caps press flips the lock state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && key_press_i && key_code_i == kta_pkg::KeyCapsLock)
      |=> (mods_q.caps != $past(mods_q.caps)))
    else $error("caps lock did not toggle");

  // Reported modifiers match the kept state after each accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (res_mods_q == mods_q))
    else $error("reported modifiers differ from kept state");

  // Held modifiers change only on an accepted event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(mods_q))
    else $error("modifier state changed without an event");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  // Keycodes inside the decoded span that map to no character
  localparam logic [7:0] KeyNonUsGap  = 8'h29;
  localparam logic [7:0] KeyNonUsHash = 8'h32;
  localparam int         ScriptLen    = 28;
  localparam int         RandomEvents = 1500;

  typedef struct packed {
    logic           char_valid;
    logic [6:0]     char_code;
    kta_pkg::mods_t mods;
  } key_result_t;

  typedef struct packed {
    logic [7:0]  key_code;
    logic        key_press;
    logic        typed;
    key_result_t result;
  } script_row_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] key_code_i  = '0;
  logic       key_press_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b1;
  logic       char_valid_o;
  logic [6:0] char_code_o;
  logic       left_shift_held_o;
  logic       right_shift_held_o;
  logic       left_ctrl_held_o;
  logic       left_alt_held_o;
  logic       caps_lock_on_o;

  kta_pkg::mods_t held_mods = '0;
  key_result_t    pending_chars [$];
  int unsigned    fault_count = 0;
  bit             calm = 1'b0;
  script_row_t    script [ScriptLen];

  keycode_to_ascii_with_modifiers_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .key_code_i         (key_code_i),
    .key_press_i        (key_press_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .char_valid_o       (char_valid_o),
    .char_code_o        (char_code_o),
    .left_shift_held_o  (left_shift_held_o),
    .right_shift_held_o (right_shift_held_o),
    .left_ctrl_held_o   (left_ctrl_held_o),
    .left_alt_held_o    (left_alt_held_o),
    .caps_lock_on_o     (caps_lock_on_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Advance the tracked modifiers, then decode a press into its character
  function automatic key_result_t decode_key_event(input logic [7:0] kc, input logic dn);
    key_result_t r;
    logic        shift;
    string       digit_row = "!@#$%^&*(";
    string       punct_row = "-=[]\\ ;'`,./";
    string       punct_up  = "_+{}| :\"~<>?";
    r = '0;
    case (kc)
      kta_pkg::KeyLeftShift:  held_mods.lshift = dn;
      kta_pkg::KeyRightShift: held_mods.rshift = dn;
      kta_pkg::KeyLeftCtrl:   held_mods.lctrl  = dn;
      kta_pkg::KeyLeftAlt:    held_mods.lalt   = dn;
      kta_pkg::KeyCapsLock:   if (dn) held_mods.caps = ~held_mods.caps;
      default: ;
    endcase
    shift = held_mods.lshift | held_mods.rshift;
    if (dn) begin
      if (kc >= kta_pkg::KeyLetterA && kc <= kta_pkg::KeyLetterZ) begin
        r.char_code = 7'(kc - kta_pkg::KeyLetterA)
                      + ((shift ^ held_mods.caps) ? 7'h41 : 7'h61);
      end else if (kc >= kta_pkg::KeyDigit1 && kc <= kta_pkg::KeyDigit9) begin
        r.char_code = shift ? 7'(digit_row[int'(kc - kta_pkg::KeyDigit1)])
                            : 7'h31 + 7'(kc - kta_pkg::KeyDigit1);
      end else if (kc == kta_pkg::KeyDigit0) begin
        r.char_code = shift ? 7'h29 : 7'h30;
      end else if (kc == kta_pkg::KeyEnter) begin
        r.char_code = 7'h0A;
      end else if (kc == kta_pkg::KeyBackspace) begin
        r.char_code = 7'h08;
      end else if (kc == kta_pkg::KeyTab) begin
        r.char_code = 7'h09;
      end else if (kc == kta_pkg::KeySpace) begin
        r.char_code = 7'h20;
      end else if (kc >= kta_pkg::KeyPunctFirst && kc <= kta_pkg::KeyPunctLast
                   && kc != KeyNonUsHash) begin
        r.char_code = shift ? 7'(punct_up[int'(kc - kta_pkg::KeyPunctFirst)])
                            : 7'(punct_row[int'(kc - kta_pkg::KeyPunctFirst)]);
      end
    end
    r.char_valid = (r.char_code != '0);
    r.mods       = held_mods;
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // Offer one key event after a random gap and hold it until it is taken
  task automatic send_key(input logic [7:0] kc, input logic dn, input logic typed,
                          input key_result_t typed_result);
    int unsigned gap;
    key_result_t r;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    key_code_i  <= kc;
    key_press_i <= dn;
    do @(posedge clk_i); while (in_stall_o);
    r = decode_key_event(kc, dn);
    pending_chars.push_back(typed ? typed_result : r);
  endtask

  // Directed events: reset values, field extremes, every key class, modifier combos
  initial begin
    script = '{
      '{8'h00,                  1'b1, 1'b1, {1'b0, 7'h00, 5'b00000}},
      '{8'hFF,                  1'b1, 1'b1, {1'b0, 7'h00, 5'b00000}},
      '{8'hFF,                  1'b0, 1'b1, {1'b0, 7'h00, 5'b00000}},
      '{kta_pkg::KeyLetterA,    1'b1, 1'b1, {1'b1, 7'h61, 5'b00000}},
      '{kta_pkg::KeyLetterZ,    1'b1, 1'b1, {1'b1, 7'h7A, 5'b00000}},
      '{kta_pkg::KeyLeftShift,  1'b1, 1'b1, {1'b0, 7'h00, 5'b00001}},
      '{kta_pkg::KeyLetterA,    1'b1, 1'b0, '0},
      '{kta_pkg::KeyDigit1,     1'b1, 1'b0, '0},
      '{kta_pkg::KeyDigit0,     1'b1, 1'b0, '0},
      '{kta_pkg::KeyPunctFirst, 1'b1, 1'b0, '0},
      '{kta_pkg::KeyPunctLast,  1'b1, 1'b0, '0},
      '{KeyNonUsHash,           1'b1, 1'b0, '0},
      '{kta_pkg::KeyLeftShift,  1'b0, 1'b0, '0},
      '{kta_pkg::KeyCapsLock,   1'b1, 1'b0, '0},
      '{kta_pkg::KeyCapsLock,   1'b0, 1'b0, '0},
      '{kta_pkg::KeyLetterZ,    1'b1, 1'b0, '0},
      '{kta_pkg::KeyRightShift, 1'b1, 1'b0, '0},
      '{kta_pkg::KeyLetterZ,    1'b1, 1'b0, '0},
      '{kta_pkg::KeyDigit9,     1'b1, 1'b0, '0},
      '{kta_pkg::KeyRightShift, 1'b0, 1'b0, '0},
      '{kta_pkg::KeyLeftCtrl,   1'b1, 1'b0, '0},
      '{kta_pkg::KeyLeftAlt,    1'b1, 1'b0, '0},
      '{kta_pkg::KeyEnter,      1'b1, 1'b0, '0},
      '{kta_pkg::KeyBackspace,  1'b1, 1'b0, '0},
      '{kta_pkg::KeyTab,        1'b1, 1'b0, '0},
      '{kta_pkg::KeySpace,      1'b1, 1'b0, '0},
      '{KeyNonUsGap,            1'b1, 1'b0, '0},
      '{kta_pkg::KeyLetterA,    1'b0, 1'b0, '0}
    };
  end

  // Reset, then the directed script, then random typing
  initial begin
    logic [7:0]  kc;
    logic        dn;
    int unsigned pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < ScriptLen; i++) begin
      send_key(script[i].key_code, script[i].key_press, script[i].typed, script[i].result);
    end

    for (int n = 0; n < RandomEvents; n++) begin
      calm = (n >= 300 && n < 400) || (n >= 1000 && n < 1100);
      // Drain everything once before going on
      if (n == 750) begin
        in_valid_i <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      dn   = 1'b1;
      if (pick < 50) begin
        kc = 8'($urandom_range(kta_pkg::KeyLetterA, kta_pkg::KeyPunctLast));
      end else if (pick < 60) begin
        kc = 8'($urandom_range(kta_pkg::KeyLetterA, kta_pkg::KeyPunctLast));
        dn = 1'b0;
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0:       kc = kta_pkg::KeyLeftCtrl;
          1:       kc = kta_pkg::KeyLeftShift;
          2:       kc = kta_pkg::KeyRightShift;
          default: kc = kta_pkg::KeyLeftAlt;
        endcase
        dn = 1'($urandom_range(0, 1));
      end else if (pick < 80) begin
        kc = kta_pkg::KeyCapsLock;
        dn = 1'($urandom_range(0, 1));
      end else begin
        kc = 8'($urandom_range(0, 255));
        dn = 1'($urandom_range(0, 1));
      end
      send_key(kc, dn, 1'b0, '0);
    end

    // Drop valid and wait for the last characters to drain
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fault_count == 0 && pending_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Take results after a random stall and compare against the oldest pending one
  initial begin
    int unsigned hold;
    key_result_t want;
    wait (rst_ni);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_chars.size() == 0) begin
        $error("unexpected result beat: char_code %h", char_code_o);
        fault_count++;
      end else begin
        want = pending_chars.pop_front();
        if (char_valid_o !== want.char_valid) begin
          $error("char_valid: expected %b, got %b", want.char_valid, char_valid_o);
          fault_count++;
        end
        if (char_code_o !== want.char_code) begin
          $error("char_code: expected %h, got %h", want.char_code, char_code_o);
          fault_count++;
        end
        if (left_shift_held_o !== want.mods.lshift) begin
          $error("left_shift_held: expected %b, got %b", want.mods.lshift, left_shift_held_o);
          fault_count++;
        end
        if (right_shift_held_o !== want.mods.rshift) begin
          $error("right_shift_held: expected %b, got %b", want.mods.rshift,
                 right_shift_held_o);
          fault_count++;
        end
        if (left_ctrl_held_o !== want.mods.lctrl) begin
          $error("left_ctrl_held: expected %b, got %b", want.mods.lctrl, left_ctrl_held_o);
          fault_count++;
        end
        if (left_alt_held_o !== want.mods.lalt) begin
          $error("left_alt_held: expected %b, got %b", want.mods.lalt, left_alt_held_o);
          fault_count++;
        end
        if (caps_lock_on_o !== want.mods.caps) begin
          $error("caps_lock_on: expected %b, got %b", want.mods.caps, caps_lock_on_o);
          fault_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/kta_pkg.sv
sv/keycode_to_ascii_with_modifiers_unit.sv
tb/sv/tb_top.sv
